// ===== rtl/core/mtwp_pkg.sv =====
package mtwp_pkg;

    localparam int COUNT_W = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX        = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] MIN_HEADER_BYTES = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] MBAP_BYTES       = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] FULL_FRAME_BYTES = COUNT_W'(12);

    localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;

    // Byte positions in the frame that carry captured fields
    typedef enum logic [3:0] {
        POS_TXN_HI   = 4'd0,
        POS_TXN_LO   = 4'd1,
        POS_PROTO_HI = 4'd2,
        POS_PROTO_LO = 4'd3,
        POS_LEN_HI   = 4'd4,
        POS_LEN_LO   = 4'd5,
        POS_UNIT     = 4'd6,
        POS_FUNC     = 4'd7,
        POS_ADDR_HI  = 4'd8,
        POS_ADDR_LO  = 4'd9,
        POS_VAL_HI   = 4'd10,
        POS_VAL_LO   = 4'd11
    } t_pos;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_BAD_PROTO   = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_BAD_FUNC    = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_byte_req;

    typedef struct packed {
        logic [15:0] txn_id;
        logic [7:0]  unit_id;
        logic [7:0]  func_code;
        logic [15:0] register_address;
        logic [15:0] register_value;
        t_status     status;
    } t_result;

endpackage

// ===== rtl/core/modbus_tcp_write_frame_parser.sv =====
// Modbus/TCP write-single-register frame parser. Takes one frame byte per
// cycle, flagged on the final byte, and gives one result per frame: the
// final byte goes into the input register, then through the capture and
// check logic into the result register. Sustained rate is one byte per
// cycle; only a final byte waits, and only while the result register still
// holds an untaken result. Status is 0 ok, 1 too short, 2 bad protocol id,
// 3 length mismatch, 4 unsupported function; the fields always show the
// bytes captured, and positions the frame never reached read as zero.
module modbus_tcp_write_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_txn_id,
    output logic [7:0]  o_unit_id,
    output logic [7:0]  o_func_code,
    output logic [15:0] o_register_address,
    output logic [15:0] o_register_value,
    output logic [2:0]  o_status
);
    import mtwp_pkg::*;

    t_byte_req in_req;
    t_byte_req s_req;
    logic      s_valid;
    logic      adv;
    logic      out_free;
    t_result   cap_result;
    logic      r_out_valid;
    t_result   r_out;

    assign in_req.frame_byte = i_frame_byte;
    assign in_req.last_byte  = i_last_byte;

    assign out_free = !r_out_valid || i_ready;
    // Non-final bytes only update state; a final byte needs the result slot.
    assign adv      = s_valid && (!s_req.last_byte || out_free);

    mtwp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (in_req),
        .i_adv   (adv),
        .o_valid (s_valid),
        .o_req   (s_req)
    );

    mtwp_field_capture u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (adv),
        .i_req    (s_req),
        .o_result (cap_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && s_req.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && s_req.last_byte) begin
            r_out <= cap_result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_txn_id           = r_out.txn_id;
    assign o_unit_id          = r_out.unit_id;
    assign o_func_code        = r_out.func_code;
    assign o_register_address = r_out.register_address;
    assign o_register_value   = r_out.register_value;
    assign o_status           = r_out.status;

    a_result_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(adv && s_req.last_byte))
        else $error("result appeared without a final byte");

    a_ok_is_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> o_func_code == FUNC_WRITE_SINGLE)
        else $error("ok status with wrong function code");

    a_no_final_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && s_req.last_byte) |-> out_free)
        else $error("final byte overwrote an untaken result");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_valid && !adv) |=> (s_valid && $stable(s_req)))
        else $error("stalled byte lost in input register");

endmodule

// ===== rtl/core/mtwp_in_stage.sv =====
module mtwp_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  mtwp_pkg::t_byte_req   i_req,
    input  logic                  i_adv,
    output logic                  o_valid,
    output mtwp_pkg::t_byte_req   o_req
);
    import mtwp_pkg::*;

    logic      r_valid;
    t_byte_req r_req;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

endmodule

// ===== rtl/core/mtwp_field_capture.sv =====
module mtwp_field_capture (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  mtwp_pkg::t_byte_req   i_req,
    output mtwp_pkg::t_result     o_result
);
    import mtwp_pkg::*;

    logic [COUNT_W-1:0] r_count, n_count;
    logic [15:0]        r_txn, n_txn;
    logic [15:0]        r_proto, n_proto;
    logic [15:0]        r_len, n_len;
    logic [7:0]         r_unit, n_unit;
    logic [7:0]         r_func, n_func;
    logic [15:0]        r_addr, n_addr;
    logic [15:0]        r_val, n_val;
    logic [COUNT_W-1:0] len_total;
    logic [7:0]         b;
    t_status            status;

    assign b = i_req.frame_byte;

    always_comb begin
        n_txn   = r_txn;
        n_proto = r_proto;
        n_len   = r_len;
        n_unit  = r_unit;
        n_func  = r_func;
        n_addr  = r_addr;
        n_val   = r_val;
        if (r_count < FULL_FRAME_BYTES) begin
            case (t_pos'(r_count[3:0]))
                POS_TXN_HI:   n_txn[15:8]   = b;
                POS_TXN_LO:   n_txn[7:0]    = b;
                POS_PROTO_HI: n_proto[15:8] = b;
                POS_PROTO_LO: n_proto[7:0]  = b;
                POS_LEN_HI:   n_len[15:8]   = b;
                POS_LEN_LO:   n_len[7:0]    = b;
                POS_UNIT:     n_unit        = b;
                POS_FUNC:     n_func        = b;
                POS_ADDR_HI:  n_addr[15:8]  = b;
                POS_ADDR_LO:  n_addr[7:0]   = b;
                POS_VAL_HI:   n_val[15:8]   = b;
                POS_VAL_LO:   n_val[7:0]    = b;
                default: ;
            endcase
        end
        n_count = (r_count < COUNT_MAX) ? r_count + 1'b1 : r_count;
    end

    // A zero length field gives a total of six, below the header minimum, so it
    // always fails the compare.
    assign len_total = {{(COUNT_W-16){1'b0}}, n_len} + (MBAP_BYTES - 1'b1);

    always_comb begin
        if (n_count < MIN_HEADER_BYTES) begin
            status = ST_TOO_SHORT;
        end else if (n_proto != 16'd0) begin
            status = ST_BAD_PROTO;
        end else if (n_count != len_total) begin
            status = ST_LEN_MISMATCH;
        end else if (n_func != FUNC_WRITE_SINGLE) begin
            status = ST_BAD_FUNC;
        end else if (n_count < FULL_FRAME_BYTES) begin
            status = ST_TOO_SHORT;
        end else begin
            status = ST_OK;
        end
    end

    assign o_result.txn_id           = n_txn;
    assign o_result.unit_id          = n_unit;
    assign o_result.func_code        = n_func;
    assign o_result.register_address = n_addr;
    assign o_result.register_value   = n_val;
    assign o_result.status           = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_req.last_byte)) begin
            r_count <= '0;
            r_txn   <= '0;
            r_proto <= '0;
            r_len   <= '0;
            r_unit  <= '0;
            r_func  <= '0;
            r_addr  <= '0;
            r_val   <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
            r_txn   <= n_txn;
            r_proto <= n_proto;
            r_len   <= n_len;
            r_unit  <= n_unit;
            r_func  <= n_func;
            r_addr  <= n_addr;
            r_val   <= n_val;
        end
    end

endmodule

// ===== sim/tb_modbus_tcp_write_frame_parser.sv =====
`timescale 1ns / 100ps

module tb_modbus_tcp_write_frame_parser;

    import mtwp_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int PHASE_BYTES    = 450;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int NO_TYPED       = -1;

    typedef struct {
        int          n;
        logic [15:0] tid;
        logic [15:0] proto;
        logic [15:0] len;
        logic [7:0]  unit;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [15:0] val;
        t_status     status;
    } t_frame_row;

    // Directed frames: sizes, header extremes and every status code
    t_frame_row dir_rows [14] = '{
        '{1,  16'hFFFF, 16'h0000, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, ST_TOO_SHORT},
        '{7,  16'h1234, 16'h0001, 16'h0001, 8'h55, 8'h06, 16'h0000, 16'h0000, ST_TOO_SHORT},
        '{7,  16'h1234, 16'h0000, 16'h0001, 8'h55, 8'h06, 16'h0000, 16'h0000, ST_TOO_SHORT},
        '{8,  16'hABCD, 16'h0000, 16'h0002, 8'h01, 8'h06, 16'h0000, 16'h0000, ST_TOO_SHORT},
        '{10, 16'h0008, 16'h0000, 16'h0004, 8'h33, 8'h06, 16'h1234, 16'h0000, ST_TOO_SHORT},
        '{12, 16'hFFFF, 16'h0000, 16'h0006, 8'hFF, 8'h06, 16'hFFFF, 16'hFFFF, ST_OK},
        '{12, 16'h0000, 16'h0000, 16'h0006, 8'h00, 8'h06, 16'h0000, 16'h0000, ST_OK},
        '{12, 16'h0001, 16'h8000, 16'h0006, 8'h11, 8'h06, 16'h0001, 16'h0002, ST_BAD_PROTO},
        '{12, 16'h0002, 16'h0000, 16'h0000, 8'h11, 8'h06, 16'h0003, 16'h0004, ST_LEN_MISMATCH},
        '{12, 16'h0003, 16'h0000, 16'h0007, 8'h11, 8'h06, 16'h0005, 16'h0006, ST_LEN_MISMATCH},
        '{12, 16'h0004, 16'h0000, 16'hFFFF, 8'h11, 8'h06, 16'h0007, 16'h0008, ST_LEN_MISMATCH},
        '{12, 16'h0005, 16'h0000, 16'h0006, 8'h22, 8'h03, 16'h0009, 16'h000A, ST_BAD_FUNC},
        '{12, 16'h0006, 16'h0000, 16'h0006, 8'h22, 8'hFF, 16'h000B, 16'h000C, ST_BAD_FUNC},
        '{15, 16'h0007, 16'h0000, 16'h0009, 8'h33, 8'h06, 16'h5A5A, 16'hA5A5, ST_OK}
    };

    int idle_tab  [4] = '{0, 84, 0, 19};
    int stall_tab [4] = '{0, 0, 84, 19};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_frame_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_txn_id;
    logic [7:0]  o_unit_id;
    logic [7:0]  o_func_code;
    logic [15:0] o_register_address;
    logic [15:0] o_register_value;
    logic [2:0]  o_status;

    // Frame capture state of the predictor
    logic [COUNT_W-1:0] acc_count = '0;
    logic [15:0]        acc_txn = '0;
    logic [15:0]        acc_proto = '0;
    logic [15:0]        acc_len = '0;
    logic [7:0]         acc_unit = '0;
    logic [7:0]         acc_func = '0;
    logic [15:0]        acc_addr = '0;
    logic [15:0]        acc_val = '0;

    t_result pending_results [$];
    int      typed_status_q [$];

    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_mode = 1'b0;
    int hold_cnt = 0;
    int cycle_cnt = 0;
    int fail_cnt = 0;
    int bytes_sent = 0;
    int frames_sent = 0;
    int results_checked = 0;

    modbus_tcp_write_frame_parser u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_frame_byte       (i_frame_byte),
        .i_last_byte        (i_last_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_txn_id           (o_txn_id),
        .o_unit_id          (o_unit_id),
        .o_func_code        (o_func_code),
        .o_register_address (o_register_address),
        .o_register_value   (o_register_value),
        .o_status           (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic parse_byte(input logic [7:0] b, input logic last, input int typed);
        t_result r;
        case (acc_count)
            COUNT_W'(POS_TXN_HI):   acc_txn[15:8]   = b;
            COUNT_W'(POS_TXN_LO):   acc_txn[7:0]    = b;
            COUNT_W'(POS_PROTO_HI): acc_proto[15:8] = b;
            COUNT_W'(POS_PROTO_LO): acc_proto[7:0]  = b;
            COUNT_W'(POS_LEN_HI):   acc_len[15:8]   = b;
            COUNT_W'(POS_LEN_LO):   acc_len[7:0]    = b;
            COUNT_W'(POS_UNIT):     acc_unit        = b;
            COUNT_W'(POS_FUNC):     acc_func        = b;
            COUNT_W'(POS_ADDR_HI):  acc_addr[15:8]  = b;
            COUNT_W'(POS_ADDR_LO):  acc_addr[7:0]   = b;
            COUNT_W'(POS_VAL_HI):   acc_val[15:8]   = b;
            COUNT_W'(POS_VAL_LO):   acc_val[7:0]    = b;
            default: ;
        endcase
        if (acc_count != COUNT_MAX)
            acc_count = acc_count + 1'b1;
        if (last) begin
            if (acc_count < MIN_HEADER_BYTES)
                r.status = ST_TOO_SHORT;
            else if (acc_proto != 16'h0000)
                r.status = ST_BAD_PROTO;
            else if (acc_len == 16'h0000 ||
                     acc_count - MBAP_BYTES != COUNT_W'(acc_len) - 1'b1)
                r.status = ST_LEN_MISMATCH;
            else if (acc_func != FUNC_WRITE_SINGLE)
                r.status = ST_BAD_FUNC;
            else if (acc_count < FULL_FRAME_BYTES)
                r.status = ST_TOO_SHORT;
            else
                r.status = ST_OK;
            // a directed frame carries its status typed into the table
            if (typed != NO_TYPED)
                r.status = t_status'(typed);
            r.txn_id           = acc_txn;
            r.unit_id          = acc_unit;
            r.func_code        = acc_func;
            r.register_address = acc_addr;
            r.register_value   = acc_val;
            pending_results = {pending_results, r};
            acc_count = '0;
            acc_txn   = '0;
            acc_proto = '0;
            acc_len   = '0;
            acc_unit  = '0;
            acc_func  = '0;
            acc_addr  = '0;
            acc_val   = '0;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            $error("result with no request pending: status %0d", o_status);
            fail_cnt++;
        end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (o_txn_id !== want.txn_id) begin
                $error("txn_id: expected %h, got %h", want.txn_id, o_txn_id);
                fail_cnt++;
            end
            if (o_unit_id !== want.unit_id) begin
                $error("unit_id: expected %h, got %h", want.unit_id, o_unit_id);
                fail_cnt++;
            end
            if (o_func_code !== want.func_code) begin
                $error("func_code: expected %h, got %h", want.func_code, o_func_code);
                fail_cnt++;
            end
            if (o_register_address !== want.register_address) begin
                $error("register_address: expected %h, got %h", want.register_address,
                       o_register_address);
                fail_cnt++;
            end
            if (o_register_value !== want.register_value) begin
                $error("register_value: expected %h, got %h", want.register_value,
                       o_register_value);
                fail_cnt++;
            end
            if (o_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, o_status);
                fail_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (i_valid && o_ready)
                parse_byte(i_frame_byte, i_last_byte,
                           i_last_byte ? typed_status_q.pop_front() : NO_TYPED);
            if (o_valid && i_ready)
                check_result();
        end
    end

    // Result side: random stalls, or one long hold-off while hold_mode is set
    always @(negedge i_clk) begin
        if (!hold_mode)
            hold_cnt = 0;
        if (hold_mode && hold_cnt < HOLD_CYCLES) begin
            hold_cnt++;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_frame_byte <= b;
        i_last_byte  <= last;
        do
            @(posedge i_clk);
        while (!o_ready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] data [], input int typed);
        typed_status_q = {typed_status_q, typed};
        frames_sent++;
        foreach (data[k])
            send_byte(data[k], k == data.size() - 1);
    endtask

    function automatic void make_frame(input int n, input logic [15:0] tid, proto, len,
                                       input logic [7:0] unit, func,
                                       input logic [15:0] addr, val,
                                       output logic [7:0] data []);
        logic [7:0] hdr [12];
        hdr = '{tid[15:8], tid[7:0], proto[15:8], proto[7:0], len[15:8], len[7:0],
                unit, func, addr[15:8], addr[7:0], val[15:8], val[7:0]};
        data = new[n];
        foreach (data[k])
            data[k] = (k < 12) ? hdr[k] : 8'($urandom);
    endfunction

    // Mostly write requests, many well-formed, some with one field broken or cut short, plus noise
    task automatic random_frame();
        logic [7:0]  data [];
        logic [15:0] proto;
        logic [15:0] len;
        logic [7:0]  func;
        int          n;
        int          kind;
        kind = $urandom_range(99);
        if (kind < 75) begin
            n     = $urandom_range(12, 16);
            proto = 16'h0000;
            len   = 16'(n - 6);
            func  = FUNC_WRITE_SINGLE;
            case ($urandom_range(9))
                0: proto = 16'($urandom_range(1, 65535));
                1: len = 16'($urandom);
                2: func = 8'($urandom);
                3: begin
                    n = $urandom_range(1, 11);
                    len = 16'(n - 6);
                end
                default: ;
            endcase
            make_frame(n, 16'($urandom), proto, len, 8'($urandom), func, 16'($urandom),
                       16'($urandom), data);
        end else begin
            data = new[$urandom_range(1, 20)];
            foreach (data[k])
                data[k] = 8'($urandom);
        end
        send_frame(data, NO_TYPED);
    endtask

    initial begin
        logic [7:0] data [];
        int         phase_start;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            if (p == 0) begin
                foreach (dir_rows[r]) begin
                    make_frame(dir_rows[r].n, dir_rows[r].tid, dir_rows[r].proto,
                               dir_rows[r].len, dir_rows[r].unit, dir_rows[r].func,
                               dir_rows[r].addr, dir_rows[r].val, data);
                    send_frame(data, int'(dir_rows[r].status));
                end
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_frame();
        end

        // Hold results off while one-byte frames keep coming, so the input stalls
        idle_pct  = 0;
        stall_pct = 0;
        hold_mode = 1'b1;
        for (int f = 0; f < 60; f++) begin
            data = new[1];
            data[0] = 8'($urandom);
            send_frame(data, NO_TYPED);
        end
        hold_mode = 1'b0;

        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Parsed %0d frames, %0d bytes: directed headers, idle and stall mixes,",
                 frames_sent, bytes_sent);
        $display("and a long result hold-off with the input backed up; %0d results compared",
                 results_checked);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
